[sv/ath_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the time histogram unit.
package ath_pkg;

  localparam int NUM_BINS  = 200;
  localparam int NUM_HIST  = 8;
  localparam int TIME_BITS = 40;
  localparam int HIST_W    = 3;
  localparam int BIN_W     = 8;
  localparam int SIZE_W    = 48;
  localparam int CFG_W     = 20;
  localparam int LEVEL_W   = 6;
  localparam int CNT_W     = 64;
  localparam int OUT_CNT_W = 63;
  localparam int WIDTH_W   = 63;
  localparam int PROD_W    = SIZE_W + TIME_BITS;
  localparam int TOTAL     = NUM_BINS * NUM_HIST;
  localparam int ADDR_W    = $clog2(TOTAL);
  localparam int HALF      = (NUM_BINS + 1) / 2;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 144;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(100000);
  localparam logic [LEVEL_W-1:0] LEVEL_TOP = '1;

  localparam logic [1:0] FUNC_UPDATE   = 2'd0;
  localparam logic [1:0] FUNC_FINALIZE = 2'd1;
  localparam logic [1:0] FUNC_READ     = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MD_DIV_START,
    MD_DIV_FINAL,
    MD_MULDIV
  } md_op_t;

  typedef struct packed {
    logic    load_item;
    logic    clr_wr;
    logic    hcur_item;
    logic    hcur_zero;
    logic    hcur_inc;
    logic    freeze;
    logic    load_w;
    logic    col_init;
    logic    col_rd_a;
    logic    col_rd_b;
    logic    col_wr;
    logic    col_clr;
    logic    level_inc;
    logic    md_start;
    md_op_t  md_op;
    logic    first_load;
    logic    bin_rd;
    logic    bin_wr;
    logic    nv_load;
    logic    sel_rd;
    logic    sel_latch;
    logic    emit;
    status_t code;
  } ath_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       clr_done;
    logic       size_zero;
    logic       frozen;
    logic       end_before_start;
    logic       grow_needed;
    logic       pair_last;
    logic       clr_last;
    logic       md_done;
    logic       bin_done;
    logic       dur_zero;
    logic       hcur_last;
    logic       out_busy;
  } ath_stat_t;

endpackage

[sv/adaptive_time_histogram_unit.sv]
// Top level of the adaptive bin width time histogram unit.
// Eight histograms of 200 read and 200 write byte bins are kept in two 1600-entry RAMs
// with one read and one write port each. After reset a clearing pass writes every entry,
// during which no item is taken (configuration writes are). Items are handled one at a
// time. A read after finalize needs one pass of the serial multiply-divide unit (40
// multiply steps, one add, 88 divide steps) to find the valid bin count. An ignored or
// rejected update goes from decode straight to the emit state. An update adds its
// bytes to each covered bin in turn, with a multiply-divide pass per bin unless start
// equals end, after any collapses; each collapse merges bin pairs by a read, read, write
// sequence over the RAM port and then clears the upper half one bin per cycle. Finalize
// visits every histogram in turn and collapses it where needed. A finished result waits
// in the output register while the next item is taken.
module adaptive_time_histogram_unit import ath_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // heatmap_index, is_write, size_bytes, start_ticks, end_ticks, bin_select
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // func
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // write_bytes, read_bytes, width_level, valid_bins, has_data
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status
  output logic [1:0]            m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  ath_cmd_t             cmd;
  ath_stat_t            stat;
  status_t              out_status;
  logic [OUT_CNT_W-1:0] out_write_bytes;
  logic [OUT_CNT_W-1:0] out_read_bytes;
  logic [LEVEL_W-1:0]   out_level;
  logic [BIN_W-1:0]     out_valid_bins;
  logic                 out_has_data;
  logic                 in_ready;

  assign s_tready  = in_ready;
  assign cfg_ready = 1'b1;
  assign m_tuser   = out_status;
  assign m_tdata   = {3'b000, out_has_data, out_valid_bins, out_level,
                      out_read_bytes, out_write_bytes};

  ath_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ath_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .in_func         (s_tuser),
    .in_hist         (s_tdata[2:0]),
    .in_wr           (s_tdata[3]),
    .in_size         (s_tdata[51:4]),
    .in_start        (s_tdata[91:52]),
    .in_end          (s_tdata[131:92]),
    .in_sel          (s_tdata[139:132]),
    .cfg_we          (cfg_valid),
    .cfg_value       (cfg_data),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .out_status      (out_status),
    .out_write_bytes (out_write_bytes),
    .out_read_bytes  (out_read_bytes),
    .out_level       (out_level),
    .out_valid_bins  (out_valid_bins),
    .out_has_data    (out_has_data)
  );

endmodule

[sv/ath_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module ath_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1600,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/ath_muldiv.sv]
// Serial unit that computes floor((a * b + c) / d) and the remainder, one bit per cycle.
module ath_muldiv import ath_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [SIZE_W-1:0]    a,
  input  logic [TIME_BITS-1:0] b,
  input  logic [TIME_BITS-1:0] c,
  input  logic [WIDTH_W-1:0]   d,
  output logic                 done,
  output logic [CNT_W-1:0]     q,
  output logic [CNT_W-1:0]     r
);

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_ADD,
    MD_DIV
  } md_state_t;

  md_state_t            state;
  logic [6:0]           count;
  logic [PROD_W-1:0]    prod;
  logic [SIZE_W-1:0]    a_hold;
  logic [TIME_BITS-1:0] c_hold;
  logic [WIDTH_W-1:0]   d_hold;
  logic [SIZE_W:0]      mul_sum;
  logic [CNT_W-1:0]     rem_shift;
  logic                 sub_ok;

  assign mul_sum   = {1'b0, prod[PROD_W-1:TIME_BITS]} + {1'b0, (prod[0] ? a_hold : '0)};
  assign rem_shift = {r[CNT_W-2:0], prod[PROD_W-1]};
  assign sub_ok    = rem_shift >= {1'b0, d_hold};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        MD_IDLE: begin
          if (start) begin
            state <= MD_MUL;
            count <= '0;
          end
        end
        MD_MUL: begin
          if (count == 7'(TIME_BITS - 1)) begin
            state <= MD_ADD;
          end
          count <= count + 7'd1;
        end
        MD_ADD: begin
          state <= MD_DIV;
          count <= '0;
        end
        MD_DIV: begin
          if (count == 7'(PROD_W - 1)) begin
            state <= MD_IDLE;
            done  <= 1'b1;
          end
          count <= count + 7'd1;
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MD_IDLE: begin
        if (start) begin
          a_hold <= a;
          c_hold <= c;
          d_hold <= d;
          prod   <= {{SIZE_W{1'b0}}, b};
          q      <= '0;
          r      <= '0;
        end
      end
      MD_MUL: prod <= {mul_sum, prod[TIME_BITS-1:1]};
      MD_ADD: prod <= prod + PROD_W'(c_hold);
      MD_DIV: begin
        prod <= {prod[PROD_W-2:0], 1'b0};
        q    <= {q[CNT_W-2:0], sub_ok};
        r    <= sub_ok ? rem_shift - CNT_W'(d_hold) : rem_shift;
      end
      default: prod <= prod;
    endcase
  end

endmodule

[sv/ath_datapath.sv]
// Datapath of the time histogram unit: item registers, histogram state, bin RAMs and arithmetic.
module ath_datapath import ath_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            in_func,
  input  logic [HIST_W-1:0]     in_hist,
  input  logic                  in_wr,
  input  logic [SIZE_W-1:0]     in_size,
  input  logic [TIME_BITS-1:0]  in_start,
  input  logic [TIME_BITS-1:0]  in_end,
  input  logic [BIN_W-1:0]      in_sel,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_value,
  input  ath_cmd_t              cmd,
  output ath_stat_t             stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output status_t               out_status,
  output logic [OUT_CNT_W-1:0]  out_write_bytes,
  output logic [OUT_CNT_W-1:0]  out_read_bytes,
  output logic [LEVEL_W-1:0]    out_level,
  output logic [BIN_W-1:0]      out_valid_bins,
  output logic                  out_has_data
);

  localparam logic [WIDTH_W-1:0] W_SAT = {1'b1, {(WIDTH_W - 1){1'b0}}};
  localparam int SHIFT_W = CFG_W + WIDTH_W;
  localparam int W200_W  = WIDTH_W + 8;

  logic [1:0]           item_func;
  logic [HIST_W-1:0]    item_hist;
  logic                 item_wr;
  logic [SIZE_W-1:0]    item_size;
  logic [TIME_BITS-1:0] item_start;
  logic [TIME_BITS-1:0] item_end;
  logic [BIN_W-1:0]     item_sel;

  logic [CFG_W-1:0]     base;
  logic [LEVEL_W-1:0]   level [NUM_HIST];
  logic [NUM_HIST-1:0]  nonempty;
  logic                 frozen;
  logic [TIME_BITS-1:0] final_end;
  logic [HIST_W-1:0]    hcur;
  logic [WIDTH_W-1:0]   w;
  logic [ADDR_W-1:0]    clr_idx;
  logic [BIN_W-1:0]     col_i;
  logic [CNT_W-1:0]     a_w;
  logic [CNT_W-1:0]     a_r;
  logic [BIN_W-1:0]     bin_b;
  logic [CNT_W-1:0]     bottom;
  logic [BIN_W-1:0]     nv;
  logic [OUT_CNT_W-1:0] sel_w;
  logic [OUT_CNT_W-1:0] sel_r;

  logic [CFG_W-1:0]     base_eff;
  logic [SHIFT_W-1:0]   shifted;
  logic [WIDTH_W-1:0]   w_next;
  logic [W200_W-1:0]    w200;
  logic [ADDR_W-1:0]    hbase;
  logic [TIME_BITS-1:0] dur;
  logic [CNT_W-1:0]     top;
  logic [CNT_W-1:0]     ov_lo;
  logic [CNT_W-1:0]     ov_hi;
  logic [CNT_W-1:0]     ov_full;
  logic [CNT_W-1:0]     bytes;
  logic                 pair_ok;
  logic [BIN_W-1:0]     nv_calc;
  logic                 sel_ok;

  logic                 md_done;
  logic [CNT_W-1:0]     md_q;
  logic [CNT_W-1:0]     md_r;
  logic [SIZE_W-1:0]    md_a;
  logic [TIME_BITS-1:0] md_b;
  logic [TIME_BITS-1:0] md_c;
  logic [WIDTH_W-1:0]   md_d;

  logic                 we_w;
  logic                 we_r;
  logic [ADDR_W-1:0]    waddr;
  logic [CNT_W-1:0]     wdata_w;
  logic [CNT_W-1:0]     wdata_r;
  logic                 re;
  logic [ADDR_W-1:0]    raddr;
  logic [CNT_W-1:0]     rdata_w;
  logic [CNT_W-1:0]     rdata_r;

  assign base_eff = (base == '0) ? CFG_W'(1) : base;
  assign shifted  = SHIFT_W'(base_eff) << level[hcur];
  assign w_next   = (|shifted[SHIFT_W-1:WIDTH_W-1]) ? W_SAT : shifted[WIDTH_W-1:0];
  assign w200     = (W200_W'(w) << 7) + (W200_W'(w) << 6) + (W200_W'(w) << 3);
  assign hbase    = ADDR_W'(hcur) * ADDR_W'(NUM_BINS);
  assign dur      = item_end - item_start;
  assign top      = bottom + CNT_W'(w);
  assign ov_lo    = (CNT_W'(item_start) > bottom) ? CNT_W'(item_start) : bottom;
  assign ov_hi    = (CNT_W'(item_end) < top) ? CNT_W'(item_end) : top;
  assign ov_full  = ov_hi - ov_lo;
  assign bytes    = (dur == '0) ? CNT_W'(item_size) : md_q;
  assign pair_ok  = ((BIN_W + 1)'(col_i) * 2 + 1) < (BIN_W + 1)'(NUM_BINS);
  assign nv_calc  = (md_q >= CNT_W'(NUM_BINS)) ? BIN_W'(NUM_BINS)
                                               : md_q[BIN_W-1:0] + BIN_W'(md_r != '0);
  assign sel_ok   = item_sel < nv;

  always_comb begin
    md_a = SIZE_W'(item_start);
    md_b = TIME_BITS'(1);
    md_c = '0;
    md_d = w;
    case (cmd.md_op)
      MD_DIV_START: md_a = SIZE_W'(item_start);
      MD_DIV_FINAL: md_a = SIZE_W'(final_end);
      MD_MULDIV: begin
        md_a = item_size;
        md_b = ov_full[TIME_BITS-1:0];
        md_c = dur >> 1;
        md_d = WIDTH_W'(dur);
      end
      default: md_a = SIZE_W'(item_start);
    endcase
  end

  ath_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.md_start),
    .a     (md_a),
    .b     (md_b),
    .c     (md_c),
    .d     (md_d),
    .done  (md_done),
    .q     (md_q),
    .r     (md_r)
  );

  always_comb begin
    we_w    = 1'b0;
    we_r    = 1'b0;
    waddr   = hbase + ADDR_W'(col_i);
    wdata_w = '0;
    wdata_r = '0;
    if (cmd.clr_wr) begin
      we_w  = 1'b1;
      we_r  = 1'b1;
      waddr = clr_idx;
    end else if (cmd.col_wr) begin
      we_w    = 1'b1;
      we_r    = 1'b1;
      wdata_w = a_w + (pair_ok ? rdata_w : '0);
      wdata_r = a_r + (pair_ok ? rdata_r : '0);
    end else if (cmd.col_clr) begin
      we_w = 1'b1;
      we_r = 1'b1;
    end else if (cmd.bin_wr) begin
      we_w    = item_wr;
      we_r    = !item_wr;
      waddr   = hbase + ADDR_W'(bin_b);
      wdata_w = rdata_w + bytes;
      wdata_r = rdata_r + bytes;
    end
  end

  always_comb begin
    re    = cmd.col_rd_a | cmd.col_rd_b | cmd.bin_rd | cmd.sel_rd;
    raddr = hbase + ADDR_W'(bin_b);
    if (cmd.col_rd_a) begin
      raddr = hbase + ADDR_W'({col_i, 1'b0});
    end else if (cmd.col_rd_b) begin
      raddr = hbase + ADDR_W'({col_i, 1'b1});
    end else if (cmd.sel_rd) begin
      raddr = hbase + ADDR_W'(item_sel);
    end
  end

  ath_ram #(.WIDTH(CNT_W), .DEPTH(TOTAL)) u_write_ram (
    .clk   (clk),
    .we    (we_w),
    .waddr (waddr),
    .wdata (wdata_w),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_w)
  );

  ath_ram #(.WIDTH(CNT_W), .DEPTH(TOTAL)) u_read_ram (
    .clk   (clk),
    .we    (we_r),
    .waddr (waddr),
    .wdata (wdata_r),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= CFG_RESET;
      nonempty  <= '0;
      frozen    <= 1'b0;
      final_end <= '0;
      clr_idx   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_HIST; i++) begin
        level[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        base <= cfg_value;
      end
      if (cmd.clr_wr) begin
        clr_idx <= clr_idx + ADDR_W'(1);
      end
      if (cmd.freeze) begin
        frozen    <= 1'b1;
        final_end <= item_end;
      end
      if (cmd.level_inc) begin
        level[hcur] <= level[hcur] + LEVEL_W'(1);
      end
      if (cmd.bin_wr && bytes != '0) begin
        nonempty[hcur] <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_func  <= in_func;
      item_hist  <= in_hist;
      item_wr    <= in_wr;
      item_size  <= in_size;
      item_start <= in_start;
      item_end   <= in_end;
      item_sel   <= in_sel;
    end
    if (cmd.hcur_item) begin
      hcur <= item_hist;
    end else if (cmd.hcur_zero) begin
      hcur <= '0;
    end else if (cmd.hcur_inc) begin
      hcur <= hcur + HIST_W'(1);
    end
    if (cmd.load_w) begin
      w <= w_next;
    end
    if (cmd.col_init) begin
      col_i <= '0;
    end else if (cmd.col_wr || cmd.col_clr) begin
      col_i <= col_i + BIN_W'(1);
    end
    if (cmd.col_rd_b) begin
      a_w <= rdata_w;
      a_r <= rdata_r;
    end
    if (cmd.first_load) begin
      bin_b  <= (md_q >= CNT_W'(NUM_BINS)) ? BIN_W'(NUM_BINS) : md_q[BIN_W-1:0];
      bottom <= CNT_W'(item_start) - md_r;
    end else if (cmd.bin_wr) begin
      bin_b  <= bin_b + BIN_W'(1);
      bottom <= top;
    end
    if (cmd.nv_load) begin
      nv <= frozen ? nv_calc : BIN_W'(NUM_BINS);
    end
    if (cmd.sel_latch) begin
      sel_w <= sel_ok ? rdata_w[OUT_CNT_W-1:0] : '0;
      sel_r <= sel_ok ? rdata_r[OUT_CNT_W-1:0] : '0;
    end
    if (cmd.emit) begin
      out_status <= cmd.code;
      if (item_func == FUNC_READ) begin
        out_write_bytes <= sel_w;
        out_read_bytes  <= sel_r;
        out_level       <= level[hcur];
        out_valid_bins  <= nv;
        out_has_data    <= nonempty[hcur];
      end else begin
        out_write_bytes <= '0;
        out_read_bytes  <= '0;
        out_level       <= '0;
        out_valid_bins  <= '0;
        out_has_data    <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.func             = item_func;
    stat.clr_done         = clr_idx == ADDR_W'(TOTAL - 1);
    stat.size_zero        = item_size == '0;
    stat.frozen           = frozen;
    stat.end_before_start = item_end < item_start;
    stat.grow_needed      = (level[hcur] != LEVEL_TOP) && (W200_W'(item_end) >= w200);
    stat.pair_last        = col_i == BIN_W'(HALF - 1);
    stat.clr_last         = col_i == BIN_W'(NUM_BINS - 1);
    stat.md_done          = md_done;
    stat.bin_done         = (bin_b >= BIN_W'(NUM_BINS)) || (bottom > CNT_W'(item_end));
    stat.dur_zero         = dur == '0;
    stat.hcur_last        = hcur == HIST_W'(NUM_HIST - 1);
    stat.out_busy         = out_valid && !out_ready;
  end

endmodule

[sv/ath_ctrl.sv]
// Controller state machine that sequences clearing, collapses, updates, finalize and reads.
module ath_ctrl import ath_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ath_stat_t stat,
  output ath_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_LOADW,
    S_CHECK,
    S_COL_RA,
    S_COL_RB,
    S_COL_WR,
    S_COL_CLR,
    S_FIRST_WAIT,
    S_BIN_CHECK,
    S_BIN_WAIT,
    S_BIN_ADD,
    S_NV_WAIT,
    S_SEL,
    S_SEL_LATCH,
    S_EMIT
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t code;
  status_t code_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    code_next  = code;
    cmd        = '0;
    cmd.code   = code;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          code_next     = ST_DONE;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.func)
          FUNC_UPDATE: begin
            if (stat.size_zero || stat.frozen) begin
              code_next  = ST_IGNORED;
              state_next = S_EMIT;
            end else if (stat.end_before_start) begin
              code_next  = ST_REJECTED;
              state_next = S_EMIT;
            end else begin
              cmd.hcur_item = 1'b1;
              state_next    = S_LOADW;
            end
          end
          FUNC_FINALIZE: begin
            cmd.freeze    = 1'b1;
            cmd.hcur_zero = 1'b1;
            state_next    = S_LOADW;
          end
          FUNC_READ: begin
            cmd.hcur_item = 1'b1;
            state_next    = S_LOADW;
          end
          default: begin
            code_next  = ST_IGNORED;
            state_next = S_EMIT;
          end
        endcase
      end
      S_LOADW: begin
        cmd.load_w = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.func == FUNC_READ) begin
          if (stat.frozen) begin
            cmd.md_start = 1'b1;
            cmd.md_op    = MD_DIV_FINAL;
            state_next   = S_NV_WAIT;
          end else begin
            cmd.nv_load = 1'b1;
            state_next  = S_SEL;
          end
        end else if (stat.grow_needed) begin
          cmd.col_init = 1'b1;
          state_next   = S_COL_RA;
        end else if (stat.func == FUNC_UPDATE) begin
          cmd.md_start = 1'b1;
          cmd.md_op    = MD_DIV_START;
          state_next   = S_FIRST_WAIT;
        end else if (stat.hcur_last) begin
          state_next = S_EMIT;
        end else begin
          cmd.hcur_inc = 1'b1;
          state_next   = S_LOADW;
        end
      end
      S_COL_RA: begin
        cmd.col_rd_a = 1'b1;
        state_next   = S_COL_RB;
      end
      S_COL_RB: begin
        cmd.col_rd_b = 1'b1;
        state_next   = S_COL_WR;
      end
      S_COL_WR: begin
        cmd.col_wr = 1'b1;
        state_next = stat.pair_last ? S_COL_CLR : S_COL_RA;
      end
      S_COL_CLR: begin
        cmd.col_clr = 1'b1;
        if (stat.clr_last) begin
          cmd.level_inc = 1'b1;
          state_next    = S_LOADW;
        end
      end
      S_FIRST_WAIT: begin
        if (stat.md_done) begin
          cmd.first_load = 1'b1;
          state_next     = S_BIN_CHECK;
        end
      end
      S_BIN_CHECK: begin
        if (stat.bin_done) begin
          state_next = S_EMIT;
        end else begin
          cmd.bin_rd = 1'b1;
          if (stat.dur_zero) begin
            state_next = S_BIN_ADD;
          end else begin
            cmd.md_start = 1'b1;
            cmd.md_op    = MD_MULDIV;
            state_next   = S_BIN_WAIT;
          end
        end
      end
      S_BIN_WAIT: begin
        if (stat.md_done) begin
          state_next = S_BIN_ADD;
        end
      end
      S_BIN_ADD: begin
        cmd.bin_wr = 1'b1;
        state_next = S_BIN_CHECK;
      end
      S_NV_WAIT: begin
        if (stat.md_done) begin
          cmd.nv_load = 1'b1;
          state_next  = S_SEL;
        end
      end
      S_SEL: begin
        cmd.sel_rd = 1'b1;
        state_next = S_SEL_LATCH;
      end
      S_SEL_LATCH: begin
        cmd.sel_latch = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      code  <= ST_DONE;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

endmodule
